// ----- sv/wheel_velocity_pid_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the wheel velocity PID block.
// The clock and reset names are passed in explicitly or taken as clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef WHEEL_VELOCITY_PID_TOP_MACROS_SVH
`define WHEEL_VELOCITY_PID_TOP_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define WVP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the standard clk_i and rst_ni of a module.
`define WVP_ASSERT(label, prop, msg) \
  `WVP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/wvpid_pkg.sv -----
// ----------------------------------------------------------------------------
// wvpid_pkg
// Types, constants and codes shared by the wheel velocity PID modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wvpid_pkg;

  localparam int unsigned DUTY_LIMIT_DEF     = 255;
  localparam int unsigned COUNTS_PER_REV_DEF = 374;

  localparam longint unsigned PI_DEN = 64'd2199114400;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned TGT_SPD_W  = 16;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned SPD_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned ACC_W      = 58;
  localparam int unsigned TGT_Q_W    = 21;
  localparam int unsigned MEAS_Q_W   = 28;
  localparam int unsigned DMAG_W     = 22;
  localparam int unsigned MUL_A_W    = SUM_W + 1;
  localparam int unsigned MUL_B_W    = 23;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] KP_RESET = 16'd205;
  localparam logic [GAIN_W-1:0] KI_RESET = 16'd77;
  localparam logic [GAIN_W-1:0] KD_RESET = 16'd26;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD         = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0]     encoder_position;
    logic signed [TGT_SPD_W-1:0] target_speed;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic                    direction_ccw;
    logic signed [SPD_W-1:0] measured_speed;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_ERR,
    S_SUM,
    S_PROP,
    S_INT,
    S_DER,
    S_WRITE
  } state_e;

  typedef enum logic [2:0] {
    MUL_TGT,
    MUL_MEAS,
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     err_en;
    logic     sum_en;
    logic     speed_en;
    acc_op_e  acc_op;
    logic     last_err_en;
    logic     out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/wvpid_dp.sv -----
// ----------------------------------------------------------------------------
// wvpid_dp
// Datapath: configuration registers, loop state, one shared signed
// multiplier with a registered product, PID accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wvpid_dp #(
  parameter int unsigned DUTY_LIMIT     = wvpid_pkg::DUTY_LIMIT_DEF,
  parameter int unsigned COUNTS_PER_REV = wvpid_pkg::COUNTS_PER_REV_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [wvpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wvpid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire wvpid_pkg::in_t                   in_data_i,
  input  wire wvpid_pkg::cmd_t                  cmd_i,
  output wvpid_pkg::out_t                       out_data_o
);

  import wvpid_pkg::*;

  localparam longint unsigned TgtQ16L =
    (64'(COUNTS_PER_REV) * 64'd65536000000 + PI_DEN / 64'd2) / PI_DEN;
  localparam longint unsigned MeasQ16L =
    (PI_DEN * 64'd65536 + 64'(COUNTS_PER_REV) * 64'd500000) /
    (64'(COUNTS_PER_REV) * 64'd1000000);
  localparam logic [TGT_Q_W-1:0]  TgtQ16   = TGT_Q_W'(TgtQ16L);
  localparam logic [MEAS_Q_W-1:0] MeasQ16  = MEAS_Q_W'(MeasQ16L);
  localparam int unsigned         DutyCapI = (DUTY_LIMIT > 255) ? 255 : DUTY_LIMIT;
  localparam logic [33:0]         DutyCap  = 34'(DutyCapI);
  localparam logic [POS_W-1:0]    SpdCap   = 32'h0020_0000;

  logic                       side_q;
  logic [GAIN_W-1:0]          kp_q, ki_q, kd_q;
  logic [POS_W-1:0]           last_pos_q;
  logic signed [POS_W-1:0]    diff_q, diff_d;
  logic signed [TGT_SPD_W-1:0] target_q;
  logic signed [ERR_W-1:0]    err_q, err_d, last_err_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SPD_W-1:0]    meas_q, meas_d;
  logic signed [PROD_W-1:0]   p_q, prod;
  logic signed [ACC_W-1:0]    acc_q;
  out_t                       out_q;

  logic [POS_W-1:0]           d_raw;
  logic [POS_W-1:0]           dabs;
  logic [DMAG_W-1:0]          dmag;
  logic signed [ERR_W:0]      de;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [49:0]         e_full;
  logic signed [SUM_W:0]      s_full;
  logic [49:0]                sp_round;
  logic [33:0]                sp_scaled;
  logic [ACC_W-1:0]           acc_abs;
  logic [33:0]                mag_sh;
  logic [DUTY_W-1:0]          duty;

  always_comb begin
    d_raw  = $unsigned(in_data_i.encoder_position) - last_pos_q;
    diff_d = side_q ? $signed(32'd0 - d_raw) : $signed(d_raw);

    dabs = diff_q[POS_W-1] ? (32'd0 - $unsigned(diff_q)) : $unsigned(diff_q);
    dmag = (dabs > SpdCap) ? DMAG_W'(SpdCap) : dabs[DMAG_W-1:0];
    de   = (ERR_W+1)'(err_q) - (ERR_W+1)'(last_err_q);
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_TGT: begin
        mul_a = MUL_A_W'(target_q);
        mul_b = MUL_B_W'(TgtQ16);
      end
      MUL_MEAS: begin
        mul_a = MUL_A_W'(MeasQ16);
        mul_b = MUL_B_W'(dmag);
      end
      MUL_KP: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_W'(kp_q);
      end
      MUL_KI: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = MUL_B_W'(ki_q);
      end
      MUL_KD: begin
        mul_a = MUL_A_W'(de);
        mul_b = MUL_B_W'(kd_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    e_full = 50'(p_q) - 50'($signed({diff_q, 16'h0000}));
    if ((&e_full[49:31]) || !(|e_full[49:31])) begin
      err_d = e_full[31:0];
    end else begin
      err_d = e_full[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    s_full = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err_q);
    if (s_full[SUM_W] == s_full[SUM_W-1]) begin
      sum_d = s_full[SUM_W-1:0];
    end else begin
      sum_d = s_full[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end

    sp_round  = p_q[49:0] + 50'h8000;
    sp_scaled = sp_round[49:16];
    if (diff_q[POS_W-1]) begin
      meas_d = (sp_scaled > 34'd32768) ? 16'sh8000 : $signed(16'd0 - sp_scaled[15:0]);
    end else begin
      meas_d = (sp_scaled > 34'd32767) ? 16'sh7FFF : $signed(sp_scaled[15:0]);
    end

    acc_abs = acc_q[ACC_W-1] ? (ACC_W'(0) - $unsigned(acc_q)) : $unsigned(acc_q);
    mag_sh  = acc_abs[ACC_W-1:24];
    duty    = (mag_sh > DutyCap) ? DutyCap[DUTY_W-1:0] : mag_sh[DUTY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 1'b0;
      kp_q   <= KP_RESET;
      ki_q   <= KI_RESET;
      kd_q   <= KD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WHEEL_SIDE: side_q <= cfg_data_i[0];
        CFG_KP:         kp_q   <= cfg_data_i;
        CFG_KI:         ki_q   <= cfg_data_i;
        CFG_KD:         kd_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
      sum_q      <= '0;
      last_err_q <= '0;
    end else begin
      if (cmd_i.load) begin
        last_pos_q <= $unsigned(in_data_i.encoder_position);
      end
      if (cmd_i.sum_en) begin
        sum_q <= sum_d;
      end
      if (cmd_i.last_err_en) begin
        last_err_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (cmd_i.load) begin
      diff_q   <= diff_d;
      target_q <= in_data_i.target_speed;
    end
    if (cmd_i.err_en) begin
      err_q <= err_d;
    end
    if (cmd_i.speed_en) begin
      meas_q <= meas_d;
    end
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(p_q);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(p_q);
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.out_load) begin
      out_q.duty           <= duty;
      out_q.direction_ccw  <= acc_q[ACC_W-1] ^ side_q;
      out_q.measured_speed <= meas_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- sv/wvpid_ctrl.sv -----
// ----------------------------------------------------------------------------
// wvpid_ctrl
// Controller: steps the shared multiplier through one control period and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wheel_velocity_pid_top_macros.svh"

module wvpid_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output wvpid_pkg::cmd_t cmd_o
);

  import wvpid_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.mul_sel     = MUL_TGT;
    cmd_o.acc_op      = ACC_HOLD;
    in_stall_o        = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TGT;
        end
      end
      S_TGT: begin
        cmd_o.mul_sel = MUL_TGT;
        state_d       = S_ERR;
      end
      S_ERR: begin
        cmd_o.err_en  = 1'b1;
        cmd_o.mul_sel = MUL_MEAS;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en   = 1'b1;
        cmd_o.speed_en = 1'b1;
        cmd_o.mul_sel  = MUL_KP;
        state_d        = S_PROP;
      end
      S_PROP: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_KI;
        state_d       = S_INT;
      end
      S_INT: begin
        cmd_o.acc_op      = ACC_ADD;
        cmd_o.mul_sel     = MUL_KD;
        cmd_o.last_err_en = 1'b1;
        state_d           = S_DER;
      end
      S_DER: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `WVP_ASSERT(a_accept_then_busy, (in_valid_i && !in_stall_o) |=> in_stall_o, "input taken while busy")
  `WVP_ASSERT(a_no_overwrite, cmd_o.out_load |-> (!out_valid_q || !out_stall_i), "result overwritten")
  `WVP_ASSERT(a_load_shows_valid, cmd_o.out_load |=> out_valid_q, "loaded result not presented")

endmodule

`default_nettype wire

// ----- sv/wheel_velocity_pid_top.sv -----
// ----------------------------------------------------------------------------
// wheel_velocity_pid_top
// Velocity PID for one encoder-driven wheel: duty, direction, measured speed.
// ----------------------------------------------------------------------------
// Usage: once per control period present the encoder position and the target
// speed on in_data_i with in_valid_i; the transaction completes when
// in_stall_o is low. One result transaction follows on out_data_o with
// out_valid_o and completes when out_stall_i is low.
// A new input transaction is taken only once the controller has stepped
// through the accept step, five products on the single shared 41x23
// multiplier, the last accumulation and the write.
// The result register is separate, so the next transaction is taken while a
// result waits; if it still waits when the next result is ready, the
// controller holds in its write step and in_stall_o stays high.
// Reset clears the last position, the error integral and the last error, and
// restores the gains and wheel side to their defaults.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i;
// the user must do so while no transaction is in flight (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_velocity_pid_top #(
  parameter int unsigned DUTY_LIMIT     = wvpid_pkg::DUTY_LIMIT_DEF,
  parameter int unsigned COUNTS_PER_REV = wvpid_pkg::COUNTS_PER_REV_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire wvpid_pkg::in_t                   in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output wvpid_pkg::out_t                       out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [wvpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wvpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import wvpid_pkg::*;

  cmd_t cmd;

  wvpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  wvpid_dp #(
    .DUTY_LIMIT     (DUTY_LIMIT),
    .COUNTS_PER_REV (COUNTS_PER_REV)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
